[hw/rtl/fpd_pkg.sv]
// shared types and constants for the four-point derivative stream
// no dependencies; imported by every module of the block
package fpd_pkg;

    localparam int POS_W       = 16;
    localparam int SLOPE_W     = 32;
    localparam int SCALE_W     = 24;
    localparam int FRAC_BITS   = 16;
    localparam int SUM_GROWTH  = 6;
    localparam int WIN_DEPTH   = 5;
    localparam int MAX_RESULTS = 5;
    localparam int COUNT_W     = $clog2(MAX_RESULTS + 1);

    localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(10923);

    typedef logic [COUNT_W-1:0] t_count;
    typedef logic [POS_W-1:0]   t_pos;

    localparam t_count FILL_FIRST = COUNT_W'(WIN_DEPTH - 1);
    localparam t_count FILL_FULL  = COUNT_W'(WIN_DEPTH);
    localparam t_count ONE_LEFT   = COUNT_W'(1);

    // one sample's worth of results waiting to be issued
    typedef struct packed {
        t_count cnt;
        t_pos   pos;
        logic   last;
        logic   err;
    } t_job_ctl;

    // side fields of one result
    typedef struct packed {
        t_pos pos;
        logic last;
        logic err;
    } t_beat_ctl;

endpackage

[hw/rtl/fpd_window.sv]
// sample window, fill count and position counter, plus the stencil sums
// for the item being accepted; depends on fpd_pkg
module fpd_window #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int SUM_W        = 22
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_accept,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
    input  logic                           i_final,
    output logic signed [SUM_W-1:0]        o_sum [fpd_pkg::MAX_RESULTS],
    output fpd_pkg::t_job_ctl              o_ctl
);
    import fpd_pkg::*;

    logic signed [SAMPLE_WIDTH-1:0] r_win [WIN_DEPTH];
    t_count                         r_fill, n_fill;
    t_pos                           r_pos, n_pos;

    logic signed [SUM_W-1:0] e [WIN_DEPTH + 1];
    logic signed [SUM_W-1:0] sum_first, sum_inner, sum_last;
    logic signed [SUM_W-1:0] sum_near [3];

    always_comb begin
        for (int m = 0; m < WIN_DEPTH; m++) begin
            e[m] = SUM_W'(r_win[m]);
        end
        e[WIN_DEPTH] = SUM_W'(i_sample);

        sum_first = SUM_W'(18) * e[2] - SUM_W'(11) * e[1] - SUM_W'(9) * e[3]
                  + SUM_W'(2) * e[4];
        sum_inner = SUM_W'(6) * e[2] - SUM_W'(2) * e[0] - SUM_W'(3) * e[1] - e[3];
        for (int k = 0; k < 3; k++) begin
            sum_near[k] = e[k] - SUM_W'(6) * e[k+1] + SUM_W'(3) * e[k+2]
                        + SUM_W'(2) * e[k+3];
        end
        sum_last = SUM_W'(9) * e[3] - SUM_W'(2) * e[2] - SUM_W'(18) * e[4]
                 + SUM_W'(11) * e[5];
    end

    always_comb begin
        for (int m = 0; m < MAX_RESULTS; m++) begin
            o_sum[m] = '0;
        end
        o_ctl.cnt  = '0;
        o_ctl.pos  = r_pos;
        o_ctl.last = 1'b0;
        o_ctl.err  = 1'b0;
        priority if (i_final && (r_fill < FILL_FULL)) begin
            // short run: one error result
            o_ctl.cnt  = ONE_LEFT;
            o_ctl.pos  = '0;
            o_ctl.last = 1'b1;
            o_ctl.err  = 1'b1;
        end else if (i_final) begin
            o_ctl.cnt  = COUNT_W'(MAX_RESULTS);
            o_ctl.last = 1'b1;
            o_sum[0]   = sum_inner;
            o_sum[1]   = sum_near[0];
            o_sum[2]   = sum_near[1];
            o_sum[3]   = sum_near[2];
            o_sum[4]   = sum_last;
        end else if (r_fill == FILL_FIRST) begin
            o_ctl.cnt = ONE_LEFT;
            o_sum[0]  = sum_first;
        end else if (r_fill == FILL_FULL) begin
            o_ctl.cnt = ONE_LEFT;
            o_sum[0]  = sum_inner;
        end else begin
            // window still filling: no result
            o_ctl.cnt = '0;
        end
    end

    always_comb begin
        n_fill = r_fill;
        n_pos  = r_pos;
        if (i_final) begin
            n_fill = '0;
            n_pos  = '0;
        end else begin
            if (r_fill < FILL_FULL) begin
                n_fill = r_fill + ONE_LEFT;
            end
            n_pos = r_pos + POS_W'(o_ctl.cnt);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_pos  <= '0;
        end else if (i_accept) begin
            r_fill <= n_fill;
            r_pos  <= n_pos;
        end
    end

    // window contents are qualified by the fill count
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            for (int m = 0; m < WIN_DEPTH - 1; m++) begin
                r_win[m] <= r_win[m+1];
            end
            r_win[WIN_DEPTH-1] <= i_sample;
        end
    end

endmodule

[hw/rtl/fpd_job.sv]
// holds the sums released by one item and issues them one per cycle while i_ready is high
// depends on fpd_pkg
module fpd_job #(
    parameter int SUM_W = 22
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_load,
    input  logic signed [SUM_W-1:0] i_sum [fpd_pkg::MAX_RESULTS],
    input  fpd_pkg::t_job_ctl       i_ctl,
    output logic                    o_load_ok,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic signed [SUM_W-1:0] o_sum,
    output fpd_pkg::t_beat_ctl      o_beat
);
    import fpd_pkg::*;

    logic                    r_valid;
    t_count                  r_left;
    t_pos                    r_pos;
    logic                    r_last;
    logic                    r_err;
    logic signed [SUM_W-1:0] r_sum [MAX_RESULTS];

    logic issue;
    logic last_beat;

    assign issue       = r_valid && i_ready;
    assign last_beat   = (r_left == ONE_LEFT);
    assign o_load_ok   = !r_valid || (issue && last_beat);
    assign o_valid     = r_valid;
    assign o_sum       = r_sum[0];
    assign o_beat.pos  = r_pos;
    assign o_beat.last = r_last && last_beat;
    assign o_beat.err  = r_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_left  <= '0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_left  <= i_ctl.cnt;
        end else if (issue) begin
            r_valid <= !last_beat;
            r_left  <= r_left - ONE_LEFT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_pos  <= i_ctl.pos;
            r_last <= i_ctl.last;
            r_err  <= i_ctl.err;
            for (int m = 0; m < MAX_RESULTS; m++) begin
                r_sum[m] <= i_sum[m];
            end
        end else if (issue) begin
            r_pos <= r_pos + POS_W'(1);
            for (int m = 0; m < MAX_RESULTS - 1; m++) begin
                r_sum[m] <= r_sum[m+1];
            end
        end
    end

endmodule

[hw/rtl/fpd_scale.sv]
// multiplies a stencil sum by the scale register, shifts, saturates if
// too wide, and holds it for the output channel; depends on fpd_pkg
module fpd_scale #(
    parameter int SUM_W = 22
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [SUM_W-1:0]      i_sum,
    input  fpd_pkg::t_beat_ctl           i_beat,
    input  logic [fpd_pkg::SCALE_W-1:0]  i_scale,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [fpd_pkg::SLOPE_W-1:0]  o_slope,
    output fpd_pkg::t_beat_ctl           o_beat
);
    import fpd_pkg::*;

    localparam int PROD_W = SUM_W + SCALE_W + 1;
    localparam int SH_W   = PROD_W - FRAC_BITS;

    logic                     r_m_valid;
    logic signed [PROD_W-1:0] r_prod;
    t_beat_ctl                r_m_beat;

    logic                     r_o_valid;
    logic [SLOPE_W-1:0]       r_slope;
    t_beat_ctl                r_o_beat;

    logic                     out_ready;
    logic signed [PROD_W-1:0] n_prod;
    logic signed [SH_W-1:0]   shv;
    logic [SLOPE_W-1:0]       n_slope;

    assign out_ready = !r_o_valid || i_ready;
    assign o_ready   = !r_m_valid || out_ready;
    assign n_prod    = PROD_W'(i_sum) * PROD_W'($signed({1'b0, i_scale}));
    assign shv       = r_prod[PROD_W-1:FRAC_BITS];

    generate
        if (SH_W <= SLOPE_W) begin : g_fits
            assign n_slope = SLOPE_W'(shv);
        end else begin : g_sat
            localparam logic signed [SH_W-1:0] SAT_HI =
                {{(SH_W - SLOPE_W + 1){1'b0}}, {(SLOPE_W - 1){1'b1}}};
            localparam logic signed [SH_W-1:0] SAT_LO =
                {{(SH_W - SLOPE_W + 1){1'b1}}, {(SLOPE_W - 1){1'b0}}};
            always_comb begin
                priority if (shv > SAT_HI) begin
                    n_slope = SAT_HI[SLOPE_W-1:0];
                end else if (shv < SAT_LO) begin
                    n_slope = SAT_LO[SLOPE_W-1:0];
                end else begin
                    n_slope = shv[SLOPE_W-1:0];
                end
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_m_valid <= i_valid;
            end
            if (out_ready) begin
                r_o_valid <= r_m_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_prod   <= n_prod;
            r_m_beat <= i_beat;
        end
        if (out_ready && r_m_valid) begin
            r_slope  <= n_slope;
            r_o_beat <= r_m_beat;
        end
    end

    assign o_valid = r_o_valid;
    assign o_slope = r_slope;
    assign o_beat  = r_o_beat;

endmodule

[hw/rtl/four_point_derivative_stream.sv]
// top level of the four-point derivative stream
// depends on fpd_pkg, fpd_window, fpd_job and fpd_scale
//
// usage
//   s_axis carries samples; tlast marks the final sample of a run.
//   m_axis carries one derivative estimate per sample: tdata holds slope
//   and position, tlast marks the last estimate of a run, tuser flags the
//   single error result given for a run shorter than six samples.
//   estimate i leaves once sample i+4 is taken; the final sample releases
//   the last five estimates back to back.
//   the scale register (unsigned Q8.16) is written through i_cfg_we and
//   i_cfg_wdata, by the user only while the block is idle (not enforced).
// timing
//   one sample per cycle while s_axis_tready is high; a result passes the
//   issue, product and output registers to m_axis. the final sample of a
//   full run loads five results, and s_axis_tready stays low until the last is issued.
// reset and stall
//   reset empties the pipeline, starts a new run and sets scale to 10923.
//   a stall on m_axis holds the output register and backs up through the
//   product and issue stages into s_axis_tready; nothing is dropped.
module four_point_derivative_stream #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_we,
    input  logic [fpd_pkg::SCALE_W-1:0]             i_cfg_wdata,
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  logic [((SAMPLE_WIDTH + 7) / 8) * 8-1:0] s_axis_tdata,  // sample
    input  logic                                    s_axis_tlast,  // final_sample
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    output logic [fpd_pkg::SLOPE_W + fpd_pkg::POS_W-1:0] m_axis_tdata, // slope, position
    output logic                                    m_axis_tlast,  // end_of_run
    output logic                                    m_axis_tuser   // too_short
);
    import fpd_pkg::*;

    localparam int SUM_W = SAMPLE_WIDTH + SUM_GROWTH;

    logic [SCALE_W-1:0]      r_scale;
    logic                    accept;
    logic                    load_ok;
    logic signed [SUM_W-1:0] win_sum [MAX_RESULTS];
    t_job_ctl                win_ctl;
    logic                    beat_valid;
    logic                    beat_ready;
    logic signed [SUM_W-1:0] beat_sum;
    t_beat_ctl               beat_ctl;
    logic [SLOPE_W-1:0]      out_slope;
    t_beat_ctl               out_ctl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= SCALE_RESET;
        end else if (i_cfg_we) begin
            r_scale <= i_cfg_wdata;
        end
    end

    assign s_axis_tready = load_ok;
    assign accept        = s_axis_tvalid && load_ok;

    fpd_window #(
        .SAMPLE_WIDTH(SAMPLE_WIDTH),
        .SUM_W       (SUM_W)
    ) u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(accept),
        .i_sample(s_axis_tdata[SAMPLE_WIDTH-1:0]),
        .i_final (s_axis_tlast),
        .o_sum   (win_sum),
        .o_ctl   (win_ctl)
    );

    fpd_job #(
        .SUM_W(SUM_W)
    ) u_job (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (accept && (win_ctl.cnt != '0)),
        .i_sum    (win_sum),
        .i_ctl    (win_ctl),
        .o_load_ok(load_ok),
        .o_valid  (beat_valid),
        .i_ready  (beat_ready),
        .o_sum    (beat_sum),
        .o_beat   (beat_ctl)
    );

    fpd_scale #(
        .SUM_W(SUM_W)
    ) u_scale (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(beat_valid),
        .o_ready(beat_ready),
        .i_sum  (beat_sum),
        .i_beat (beat_ctl),
        .i_scale(r_scale),
        .o_valid(m_axis_tvalid),
        .i_ready(m_axis_tready),
        .o_slope(out_slope),
        .o_beat (out_ctl)
    );

    assign m_axis_tdata = {out_ctl.pos, out_slope};
    assign m_axis_tlast = out_ctl.last;
    assign m_axis_tuser = out_ctl.err;

endmodule

[hw/rtl/fpd_checker.sv]
// port-level checks on the result channel of four_point_derivative_stream
// depends on fpd_pkg; bound to the top level below
module fpd_checker (
    input logic                                         i_clk,
    input logic                                         i_rst_n,
    input logic                                         m_axis_tvalid,
    input logic                                         m_axis_tready,
    input logic [fpd_pkg::SLOPE_W + fpd_pkg::POS_W-1:0] m_axis_tdata,
    input logic                                         m_axis_tlast,
    input logic                                         m_axis_tuser
);
    import fpd_pkg::*;

    // nothing comes out right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // a stalled item holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
             && $stable(m_axis_tuser)))
        else $error("stalled result changed");

    // error result is zero slope at position zero and closes the run
    a_short_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tlast && (m_axis_tdata == '0)))
        else $error("malformed short-run result");

    // the item after an end-of-run starts again at position zero
    a_run_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) ##1 m_axis_tvalid |->
            (m_axis_tdata[SLOPE_W + POS_W-1:SLOPE_W] == '0))
        else $error("new run does not start at position zero");

endmodule

bind four_point_derivative_stream fpd_checker u_fpd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
);
